/* src/assert_macros.svh */
// assertion helpers used by mpq_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/mpq_pkg.sv */
// ---------------------------------------------------------------------------
// mpq_pkg
// shared constants and types of the max priority queue
// ---------------------------------------------------------------------------
package mpq_pkg;
   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_PEEK   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // classified request handed from front to back
   typedef struct packed {
      logic [1:0]             action;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;
endpackage

/* src/mpq_ram.sv */
// ---------------------------------------------------------------------------
// mpq_ram
// generic single write, dual registered read memory
// ---------------------------------------------------------------------------
module mpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule

/* src/mpq_front.sv */
// ---------------------------------------------------------------------------
// mpq_front
// accepts requests and holds them in a two entry queue for the back end
// ---------------------------------------------------------------------------
module mpq_front
   import mpq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_action,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   busy,
   output logic                   q_valid,
   output req_type                q_req,
   input  logic                   q_pop
);
   req_type    slot_ff [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign busy    = (cnt_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_req   = slot_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      rd_in  = rd_ff ^ (q_pop && q_valid);
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= '{action: req_action, value: req_value};
      end
   end
endmodule

/* src/mpq_back.sv */
// ---------------------------------------------------------------------------
// mpq_back
// heap engine: sift up and sift down over the heap memory
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module mpq_back
   import mpq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  req_type                q_req,
   output logic                   q_pop,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [31:0]            rsp_top_value,
   output logic [6:0]             rsp_entry_count
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPRD = 3'd1;
   localparam logic [2:0] S_UPCM = 3'd2;
   localparam logic [2:0] S_DNRD = 3'd3;
   localparam logic [2:0] S_DNCM = 3'd4;
   localparam logic [2:0] S_DNLD = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ADDR_W-1:0]      pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] cur_ff, cur_in;
   logic                   rv_ff, rv_in;
   logic [1:0]             rs_ff, rs_in;
   logic [31:0]            rt_ff, rt_in;
   logic [6:0]             rc_ff, rc_in;

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr, ra, rb, par;
   logic [VALUE_WIDTH-1:0] wr_data, da, db, big_v;
   logic [CNT_W:0]         lft, rgt;
   logic                   use_r;
   logic [ADDR_W-1:0]      big_i;

   mpq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr_a(ra), .rd_addr_b(rb), .rd_data_a(da), .rd_data_b(db)
   );

   assign par   = (pos_ff - 1'b1) >> 1;
   assign lft   = (CNT_W+1)'({pos_ff, 1'b1});
   assign rgt   = lft + 1'b1;
   assign use_r = (rgt < {1'b0, cnt_ff}) && (db > da);
   assign big_v = use_r ? db : da;
   assign big_i = use_r ? rgt[ADDR_W-1:0] : lft[ADDR_W-1:0];

   // sequencer: insert holds the new value and moves holes up, pop moves it down
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      rv_in    = 1'b0;
      rs_in    = rs_ff;
      rt_in    = rt_ff;
      rc_in    = rc_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff;
      wr_data  = cur_ff;
      ra       = '0;
      rb       = '0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               rs_in = ST_OK;
               rt_in = '0;
               rc_in = 7'(cnt_ff);
               case (q_req.action)
                  ACT_INSERT: begin
                     if (cnt_ff == CNT_W'(CAPACITY)) begin
                        rs_in = ST_FULL;
                        rv_in = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                        rc_in  = 7'(cnt_ff + 1'b1);
                        pos_in = cnt_ff[ADDR_W-1:0];
                        cur_in = q_req.value;
                        state_in = S_UPRD;
                     end
                  end
                  ACT_POP, ACT_PEEK: begin
                     if (cnt_ff == '0) begin
                        rs_in = ST_EMPTY;
                        rv_in = 1'b1;
                     end else begin
                        ra = '0;
                        rb = ADDR_W'(cnt_ff - 1'b1);
                        if (q_req.action == ACT_POP) begin
                           cnt_in = cnt_ff - 1'b1;
                           rc_in  = 7'(cnt_ff - 1'b1);
                        end
                        state_in = (q_req.action == ACT_POP) ? S_DNLD : S_DNLD;
                        pos_in = '0;
                        cur_in = (q_req.action == ACT_POP) ? '1 : '0;
                     end
                  end
                  default: rv_in = 1'b1;
               endcase
            end
         end
         S_UPRD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               ra = par;
               state_in = S_UPCM;
            end
         end
         S_UPCM: begin
            wr_en = 1'b1;
            if (da < cur_ff) begin
               wr_data  = da;
               pos_in   = par;
               state_in = S_UPRD;
            end else begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DNLD: begin
            // da is root, db the last entry; cur all ones marks a pop
            rt_in = 32'(da);
            rv_in = 1'b0;
            if (cur_ff == '0 && rs_ff == ST_OK && rc_ff == 7'(cnt_ff)
                && !(&cur_ff)) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cur_in   = db;
               state_in = S_DNRD;
            end
         end
         S_DNRD: begin
            if (lft >= {1'b0, cnt_ff}) begin
               wr_en = 1'b1;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               ra = lft[ADDR_W-1:0];
               rb = (rgt < {1'b0, cnt_ff}) ? rgt[ADDR_W-1:0] : lft[ADDR_W-1:0];
               state_in = S_DNCM;
            end
         end
         S_DNCM: begin
            wr_en = 1'b1;
            if (cur_ff < big_v) begin
               wr_data  = big_v;
               pos_in   = big_i;
               state_in = S_DNRD;
            end else begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      rs_ff  <= rs_in;
      rt_ff  <= rt_in;
      rc_ff  <= rc_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rs_ff;
   assign rsp_top_value   = rt_ff;
   assign rsp_entry_count = rc_ff;

   `ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_pop_one, clock, reset, q_pop, state_ff != S_IDLE || rv_ff)
   `ASSERT_IMPL(a_idle_pop, clock, reset, q_pop, state_ff == S_IDLE)
endmodule

/* src/max_priority_queue.sv */
// ---------------------------------------------------------------------------
// max_priority_queue
// bounded max heap priority queue with insert, pop and peek
// ---------------------------------------------------------------------------
// status-only results come straight from the idle state; sift results follow the heap walk
// the back end takes one request per result, walking the heap one level per read and
//   compare state pair through the dual read memory; the front queue holds two waiting requests
// reset: synchronous, clears count and queue; heap memory is not cleared
// results are strobed once on rsp_valid; the receiver cannot stall
module max_priority_queue
   import mpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_top_value,
   output logic [6:0]  rsp_entry_count
);
   logic    q_valid, q_pop;
   req_type q_req;

   mpq_front u_front (
      .clock(clock), .reset(reset), .start(start),
      .req_action(req_action), .req_value(VALUE_WIDTH'(req_value)),
      .busy(busy), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
   );

   mpq_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_req(q_req),
      .q_pop(q_pop), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value), .rsp_entry_count(rsp_entry_count)
   );
endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// checks the max priority queue against a behavioral heap with insert, pop
// and peek requests, directed corner cases first and then random traffic
// ---------------------------------------------------------------------------
module tb_top;
   import mpq_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_top_value;
   logic [6:0]  rsp_entry_count;

   max_priority_queue dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value), .rsp_entry_count(rsp_entry_count)
   );

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] top_value;
      logic [6:0]  entry_count;
   } outcome_type;

   // behavioral heap state
   logic [31:0] heap_mirror [CAPACITY];
   int          heap_size;
   outcome_type outcome_q [$];

   int mismatches;
   int results_seen;
   int requests_sent;
   int send_idle_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end

   // heap update for one request, giving the expected outcome
   function automatic outcome_type predict_heap(logic [1:0] action, logic [31:0] value);
      outcome_type o;
      int pos, up, l, r, big;
      logic [31:0] t;
      o.status = ST_OK;
      o.top_value = '0;
      if (action == ACT_INSERT) begin
         if (heap_size >= CAPACITY) begin
            o.status = ST_FULL;
         end else begin
            heap_mirror[heap_size] = value;
            pos = heap_size;
            heap_size++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_mirror[up] < heap_mirror[pos]) begin
                  t = heap_mirror[up];
                  heap_mirror[up] = heap_mirror[pos];
                  heap_mirror[pos] = t;
                  pos = up;
               end else break;
            end
         end
      end else if (action == ACT_POP) begin
         if (heap_size == 0) begin
            o.status = ST_EMPTY;
         end else begin
            o.top_value = heap_mirror[0];
            heap_size--;
            heap_mirror[0] = heap_mirror[heap_size];
            pos = 0;
            forever begin
               l = 2 * pos + 1;
               r = l + 1;
               if (l >= heap_size) break;
               if (r >= heap_size || heap_mirror[l] >= heap_mirror[r]) big = l;
               else big = r;
               if (heap_mirror[pos] < heap_mirror[big]) begin
                  t = heap_mirror[pos];
                  heap_mirror[pos] = heap_mirror[big];
                  heap_mirror[big] = t;
                  pos = big;
               end else break;
            end
         end
      end else if (action == ACT_PEEK) begin
         if (heap_size == 0) o.status = ST_EMPTY;
         else o.top_value = heap_mirror[0];
      end
      o.entry_count = 7'(heap_size);
      return o;
   endfunction

   // compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: status %0d top %0h count %0d",
                        rsp_status, rsp_top_value, rsp_entry_count);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_status !== want.status || rsp_top_value !== want.top_value ||
                rsp_entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected status %0d top %0h count %0d, got %0d %0h %0d",
                           want.status, want.top_value, want.entry_count,
                           rsp_status, rsp_top_value, rsp_entry_count);
            end
         end
      end
   end

   // send one request, with an optional random gap before it
   task automatic send_request(logic [1:0] action, logic [31:0] value);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= action;
      req_value <= value;
      do @(posedge clock); while (busy);
      outcome_q.push_back(predict_heap(action, value));
      requests_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   // empty queue corners, extremes, ties and the unused action code
   task automatic test_directed();
      send_request(ACT_POP, 32'hFFFF_FFFF);
      send_request(ACT_PEEK, 32'h0);
      send_request(2'd3, 32'h1234_5678);
      send_request(ACT_INSERT, 32'h0);
      send_request(ACT_INSERT, 32'hFFFF_FFFF);
      send_request(ACT_INSERT, 32'h5555_5555);
      send_request(ACT_INSERT, 32'hAAAA_AAAA);
      send_request(ACT_INSERT, 32'hAAAA_AAAA);
      send_request(ACT_PEEK, 32'hFFFF_FFFF);
      send_request(2'd3, 32'hFFFF_FFFF);
      repeat (6) send_request(ACT_POP, 32'h0);
      send_request(ACT_PEEK, 32'h0);
   endtask

   // fill to capacity, overflow, then drain past empty
   task automatic test_full();
      repeat (CAPACITY + 3) send_request(ACT_INSERT, $urandom_range(15, 0));
      send_request(ACT_PEEK, 32'h0);
      repeat (CAPACITY + 2) send_request(ACT_POP, 32'h0);
   endtask

   // random mix; narrow values give many ties
   task automatic test_random(int count, int insert_pct);
      logic [1:0]  action;
      logic [31:0] value;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99, 0);
         if (pick < insert_pct) action = ACT_INSERT;
         else if (pick < 90) action = ACT_POP;
         else if (pick < 98) action = ACT_PEEK;
         else action = 2'd3;
         value = $urandom();
         if ($urandom_range(1, 0)) value = value & 32'h7;
         send_request(action, value);
      end
   endtask

   initial begin
      start = 1'b0;
      req_action = ACT_INSERT;
      req_value = '0;
      reset = 1'b1;
      heap_size = 0;
      mismatches = 0;
      results_seen = 0;
      requests_sent = 0;
      send_idle_pct = 37;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_full();
      test_random(250, 60);
      wait_drained();
      send_idle_pct = 72;
      test_random(250, 50);
      send_idle_pct = 0;
      test_random(250, 40);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d requests and %0d results: insert, pop, peek, unused code,",
               requests_sent, results_seen);
      $display("full and empty queue corners, ties and random gaps");
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/mpq_pkg.sv
src/mpq_ram.sv
src/mpq_front.sv
src/mpq_back.sv
src/max_priority_queue.sv
verif/tb_top.sv
